FILE: rtl/rotation_matrix_to_quaternion_macros.svh
// Assertion macros for the rotation-matrix-to-quaternion block.
// Included by the top level; depends on nothing.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// next-cycle implication, disabled while reset is low
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

FILE: rtl/rmq_pkg.sv
// Shared constants and types for the rotation-matrix-to-quaternion block.
// No dependencies.
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;

    // radicand magnitude: one plus three element terms
    localparam int RAD_W     = $clog2((1 << FRAC_BITS) + 3 * 32768);
    localparam int ROOT_W    = (RAD_W + FRAC_BITS + 1) / 2;
    localparam int SQ_IN_W   = 2 * ROOT_W;
    localparam int STEPS     = 4;
    localparam int SQ_LAT    = (ROOT_W + STEPS - 1) / STEPS;

    localparam int S_W       = ROOT_W + 1;
    localparam int MAG_W     = IN_W + 1;
    localparam int DIV_N_W   = MAG_W + FRAC_BITS + 1;
    localparam int DIV_LAT   = (DIV_N_W + STEPS - 1) / STEPS;

    typedef logic [1:0] t_branch;
    localparam t_branch BR_QW = 2'd0;
    localparam t_branch BR_QX = 2'd1;
    localparam t_branch BR_QY = 2'd2;
    localparam t_branch BR_QZ = 2'd3;

    localparam logic signed [OUT_W-1:0] Q_ONE =
        (FRAC_BITS >= OUT_W - 1) ? 16'sh7fff : OUT_W'(1 << FRAC_BITS);

endpackage

FILE: rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion (Shepperd's method), fully pipelined.
// Input channel: i_valid / o_stall with the nine matrix elements m11..m33, signed
// fixed point with FRAC_BITS fraction bits. Output channel: o_valid / i_stall with
// quaternion components w, x, y, z (saturated to 16 bits) and a degenerate flag.
// A transaction moves at a rising edge where valid is high and stall is low.
// The pipeline holds one stage for branch select and radicand, SQ_LAT root
// stages, one stage forming S and the dividends, DIV_LAT divider stages and
// the output register.
// Throughput is one matrix per cycle while the pipeline is not frozen; the
// root and the three dividers each resolve four bits per stage.
// When the output holds a result and i_stall is high, the whole pipeline
// freezes and o_stall rises in the same cycle; nothing is dropped or repeated.
// A degenerate radicand yields the identity quaternion with o_degenerate set.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Depends on rmq_pkg, rmq_isqrt, rmq_div and the assertion macro header.
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_m11,
    input  logic signed [15:0]  i_m12,
    input  logic signed [15:0]  i_m13,
    input  logic signed [15:0]  i_m21,
    input  logic signed [15:0]  i_m22,
    input  logic signed [15:0]  i_m23,
    input  logic signed [15:0]  i_m31,
    input  logic signed [15:0]  i_m32,
    input  logic signed [15:0]  i_m33,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_quat_w,
    output logic signed [15:0]  o_quat_x,
    output logic signed [15:0]  o_quat_y,
    output logic signed [15:0]  o_quat_z,
    output logic                o_degenerate
);

    localparam int SQ_LAT  = rmq_pkg::SQ_LAT;
    localparam int DIV_LAT = rmq_pkg::DIV_LAT;
    localparam int MAG_W   = rmq_pkg::MAG_W;
    localparam int NW      = rmq_pkg::DIV_N_W;
    localparam int OW      = rmq_pkg::OUT_W;

    typedef logic signed [rmq_pkg::RAD_W+1:0] t_rad;
    typedef logic signed [MAG_W:0]            t_num;

    typedef struct packed {
        rmq_pkg::t_branch        br;
        logic                    degen;
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   mag;
    } t_sq_side;

    typedef struct packed {
        rmq_pkg::t_branch            br;
        logic                        degen;
        logic [2:0]                  neg;
        logic [rmq_pkg::S_W-2:0]     big;
    } t_dv_side;

    function automatic logic signed [OW-1:0] sat_q(input logic [NW-1:0] q,
                                                    input logic neg);
        logic signed [OW-1:0] v;
        if (neg) begin
            if (q > NW'(32768)) v = 16'sh8000;
            else                v = OW'(~q + NW'(1));
        end else begin
            if (q > NW'(32767)) v = 16'sh7fff;
            else                v = OW'(q);
        end
        return v;
    endfunction

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- stage A: branch, radicand, numerators
    rmq_pkg::t_branch              n_br;
    t_rad                          n_rad;
    t_num                          n_num [3];
    t_sq_side                      n_a_side;
    logic [rmq_pkg::SQ_IN_W-1:0]   n_a_rad;

    always_comb begin
        t_rad trace;
        t_num d2332, d3113, d1221, s1221, s3113, s2332;
        trace = t_rad'(i_m11) + t_rad'(i_m22) + t_rad'(i_m33);
        priority if (trace > 0) begin
            n_br  = rmq_pkg::BR_QW;
            n_rad = t_rad'(1 << rmq_pkg::FRAC_BITS) + trace;
        end else if (i_m11 > i_m22 && i_m11 > i_m33) begin
            n_br  = rmq_pkg::BR_QX;
            n_rad = t_rad'(1 << rmq_pkg::FRAC_BITS) + t_rad'(i_m11)
                    - t_rad'(i_m22) - t_rad'(i_m33);
        end else if (i_m22 > i_m33) begin
            n_br  = rmq_pkg::BR_QY;
            n_rad = t_rad'(1 << rmq_pkg::FRAC_BITS) + t_rad'(i_m22)
                    - t_rad'(i_m11) - t_rad'(i_m33);
        end else begin
            n_br  = rmq_pkg::BR_QZ;
            n_rad = t_rad'(1 << rmq_pkg::FRAC_BITS) + t_rad'(i_m33)
                    - t_rad'(i_m11) - t_rad'(i_m22);
        end

        d2332 = t_num'(i_m23) - t_num'(i_m32);
        d3113 = t_num'(i_m31) - t_num'(i_m13);
        d1221 = t_num'(i_m12) - t_num'(i_m21);
        s1221 = t_num'(i_m12) + t_num'(i_m21);
        s3113 = t_num'(i_m31) + t_num'(i_m13);
        s2332 = t_num'(i_m23) + t_num'(i_m32);

        // numerators fill the three non-dominant components in w,x,y,z order
        unique case (n_br)
            rmq_pkg::BR_QW: begin n_num[0] = d2332; n_num[1] = d3113; n_num[2] = d1221; end
            rmq_pkg::BR_QX: begin n_num[0] = d2332; n_num[1] = s1221; n_num[2] = s3113; end
            rmq_pkg::BR_QY: begin n_num[0] = d3113; n_num[1] = s1221; n_num[2] = s2332; end
            default:        begin n_num[0] = d1221; n_num[1] = s3113; n_num[2] = s2332; end
        endcase

        n_a_side.br    = n_br;
        n_a_side.degen = (n_rad <= 0);
        for (int i = 0; i < 3; i++) begin
            n_a_side.neg[i] = n_num[i][MAG_W];
            n_a_side.mag[i] = n_num[i][MAG_W] ? MAG_W'(-n_num[i]) : MAG_W'(n_num[i]);
        end
        n_a_rad = n_a_side.degen ? '0
                : rmq_pkg::SQ_IN_W'(n_rad[rmq_pkg::RAD_W-1:0]) << rmq_pkg::FRAC_BITS;
    end

    logic                          r_vld_a;
    t_sq_side                      r_a_side;
    logic [rmq_pkg::SQ_IN_W-1:0]   r_a_rad;

    // ---------------- square root stages
    logic [rmq_pkg::ROOT_W-1:0]    w_root;
    logic [SQ_LAT-1:0]             r_vld_sq;
    t_sq_side                      r_sq_side [SQ_LAT];

    rmq_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_a_rad),
        .o_root (w_root)
    );

    // ---------------- stage B: S, dominant component, dividends
    t_sq_side                      w_sq_out;
    logic [rmq_pkg::S_W-1:0]       n_s;
    logic [rmq_pkg::S_W:0]         n_s_p2;
    logic [rmq_pkg::S_W:0]         n_big;
    t_dv_side                      n_b_side;
    logic [NW-1:0]                 n_b_num [3];

    assign w_sq_out = r_sq_side[SQ_LAT-1];

    always_comb begin
        n_s            = {w_root, 1'b0};
        n_s_p2         = {1'b0, n_s} + (rmq_pkg::S_W+1)'(2);
        n_big          = n_s_p2 >> 2;
        n_b_side.br    = w_sq_out.br;
        n_b_side.degen = w_sq_out.degen;
        n_b_side.neg   = w_sq_out.neg;
        n_b_side.big   = n_big[rmq_pkg::S_W-2:0];
        // (|n| << F) + S/2 gives round-half-up on the magnitude
        for (int i = 0; i < 3; i++) begin
            n_b_num[i] = (NW'(w_sq_out.mag[i]) << rmq_pkg::FRAC_BITS) + NW'(w_root);
        end
    end

    logic                          r_vld_b;
    t_dv_side                      r_b_side;
    logic [NW-1:0]                 r_b_num [3];
    logic [rmq_pkg::S_W-1:0]       r_b_den;

    // ---------------- divider stages
    logic [NW-1:0]                 w_quo [3];
    logic [DIV_LAT-1:0]            r_vld_dv;
    t_dv_side                      r_dv_side [DIV_LAT];

    for (genvar i = 0; i < 3; i++) begin : g_div
        rmq_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_b_num[i]),
            .i_den (r_b_den),
            .o_quo (w_quo[i])
        );
    end

    // ---------------- output stage
    t_dv_side                      w_dv_out;
    logic signed [OW-1:0]          n_quat [4];
    logic signed [OW-1:0]          n_sq0, n_sq1, n_sq2, n_big_sat;
    logic signed [OW-1:0]          r_quat [4];
    rmq_pkg::t_branch              r_out_br;
    logic                          r_out_vld;
    logic                          r_out_degen;

    assign w_dv_out = r_dv_side[DIV_LAT-1];

    always_comb begin
        n_sq0     = sat_q(w_quo[0], w_dv_out.neg[0]);
        n_sq1     = sat_q(w_quo[1], w_dv_out.neg[1]);
        n_sq2     = sat_q(w_quo[2], w_dv_out.neg[2]);
        n_big_sat = sat_q(NW'(w_dv_out.big), 1'b0);
        unique case (w_dv_out.br)
            rmq_pkg::BR_QW: begin
                n_quat[0] = n_big_sat; n_quat[1] = n_sq0;
                n_quat[2] = n_sq1;     n_quat[3] = n_sq2;
            end
            rmq_pkg::BR_QX: begin
                n_quat[0] = n_sq0;     n_quat[1] = n_big_sat;
                n_quat[2] = n_sq1;     n_quat[3] = n_sq2;
            end
            rmq_pkg::BR_QY: begin
                n_quat[0] = n_sq0;     n_quat[1] = n_sq1;
                n_quat[2] = n_big_sat; n_quat[3] = n_sq2;
            end
            default: begin
                n_quat[0] = n_sq0;     n_quat[1] = n_sq1;
                n_quat[2] = n_sq2;     n_quat[3] = n_big_sat;
            end
        endcase
        if (w_dv_out.degen) begin
            n_quat[0] = rmq_pkg::Q_ONE;
            n_quat[1] = '0;
            n_quat[2] = '0;
            n_quat[3] = '0;
        end
    end

    // ---------------- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= 1'b0;
            r_vld_sq  <= '0;
            r_vld_b   <= 1'b0;
            r_vld_dv  <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld_a   <= i_valid;
            r_vld_sq  <= {r_vld_sq[SQ_LAT-2:0], r_vld_a};
            r_vld_b   <= r_vld_sq[SQ_LAT-1];
            r_vld_dv  <= {r_vld_dv[DIV_LAT-2:0], r_vld_b};
            r_out_vld <= r_vld_dv[DIV_LAT-1];
        end
    end

    // ---------------- payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side <= n_a_side;
            r_a_rad  <= n_a_rad;
            r_sq_side[0] <= r_a_side;
            for (int k = 1; k < SQ_LAT; k++) r_sq_side[k] <= r_sq_side[k-1];
            r_b_side <= n_b_side;
            r_b_den  <= n_s;
            for (int i = 0; i < 3; i++) r_b_num[i] <= n_b_num[i];
            r_dv_side[0] <= r_b_side;
            for (int k = 1; k < DIV_LAT; k++) r_dv_side[k] <= r_dv_side[k-1];
            for (int i = 0; i < 4; i++) r_quat[i] <= n_quat[i];
            r_out_br    <= w_dv_out.br;
            r_out_degen <= w_dv_out.degen;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_quat_w     = r_quat[0];
    assign o_quat_x     = r_quat[1];
    assign o_quat_y     = r_quat[2];
    assign o_quat_z     = r_quat[3];
    assign o_degenerate = r_out_degen;

    // ---------------- assertions
    `RMQ_ASSERT_IMPL(a_degen_identity, i_clk, i_rst_n, o_valid && o_degenerate,
        o_quat_w == rmq_pkg::Q_ONE && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0)
    `RMQ_ASSERT_IMPL(a_w_branch_pos, i_clk, i_rst_n,
        o_valid && !o_degenerate && r_out_br == rmq_pkg::BR_QW, o_quat_w > 0)
    `RMQ_ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n, o_stall,
        $stable({r_vld_a, r_vld_sq, r_vld_b, r_vld_dv, r_out_vld}))

endmodule

FILE: rtl/rmq_isqrt.sv
// Pipelined integer square root, STEPS result bits per stage.
// Depends on rmq_pkg.
module rmq_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rmq_pkg::SQ_IN_W-1:0]   i_rad,
    output logic [rmq_pkg::ROOT_W-1:0]    o_root
);

    localparam int REM_W = rmq_pkg::ROOT_W + 1;

    logic [rmq_pkg::SQ_IN_W-1:0] r_x    [rmq_pkg::SQ_LAT];
    logic [REM_W-1:0]            r_rem  [rmq_pkg::SQ_LAT];
    logic [rmq_pkg::ROOT_W-1:0]  r_root [rmq_pkg::SQ_LAT];

    for (genvar g = 0; g < rmq_pkg::SQ_LAT; g++) begin : g_stage
        logic [rmq_pkg::SQ_IN_W-1:0] w_x_in;
        logic [REM_W-1:0]            w_rem_in;
        logic [rmq_pkg::ROOT_W-1:0]  w_root_in;
        logic [rmq_pkg::SQ_IN_W-1:0] n_x;
        logic [REM_W-1:0]            n_rem;
        logic [rmq_pkg::ROOT_W-1:0]  n_root;

        if (g == 0) begin : g_first
            assign w_x_in    = i_rad;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_x_in    = r_x[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
        end

        always_comb begin
            logic [REM_W+1:0] rem4;
            logic [REM_W+1:0] trial;
            n_x    = w_x_in;
            n_rem  = w_rem_in;
            n_root = w_root_in;
            rem4   = '0;
            trial  = '0;
            for (int j = 0; j < rmq_pkg::STEPS; j++) begin
                if (g * rmq_pkg::STEPS + j < rmq_pkg::ROOT_W) begin
                    rem4  = {n_rem, n_x[rmq_pkg::SQ_IN_W-1 -: 2]};
                    trial = (REM_W+2)'({n_root, 2'b01});
                    n_x   = n_x << 2;
                    if (rem4 >= trial) begin
                        n_rem  = REM_W'(rem4 - trial);
                        n_root = {n_root[rmq_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        n_rem  = REM_W'(rem4);
                        n_root = {n_root[rmq_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= n_x;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[rmq_pkg::SQ_LAT-1];

endmodule

FILE: rtl/rmq_div.sv
// Pipelined unsigned restoring divider, STEPS quotient bits per stage.
// Depends on rmq_pkg.
module rmq_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rmq_pkg::DIV_N_W-1:0]   i_num,
    input  logic [rmq_pkg::S_W-1:0]       i_den,
    output logic [rmq_pkg::DIV_N_W-1:0]   o_quo
);

    localparam int NW = rmq_pkg::DIV_N_W;
    localparam int SW = rmq_pkg::S_W;

    logic [NW-1:0] r_x   [rmq_pkg::DIV_LAT];
    logic [SW-1:0] r_rem [rmq_pkg::DIV_LAT];
    logic [NW-1:0] r_q   [rmq_pkg::DIV_LAT];
    logic [SW-1:0] r_den [rmq_pkg::DIV_LAT];

    for (genvar g = 0; g < rmq_pkg::DIV_LAT; g++) begin : g_stage
        logic [NW-1:0] w_x_in;
        logic [SW-1:0] w_rem_in;
        logic [NW-1:0] w_q_in;
        logic [SW-1:0] w_den_in;
        logic [NW-1:0] n_x;
        logic [SW-1:0] n_rem;
        logic [NW-1:0] n_q;

        if (g == 0) begin : g_first
            assign w_x_in   = i_num;
            assign w_rem_in = '0;
            assign w_q_in   = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_x_in   = r_x[g-1];
            assign w_rem_in = r_rem[g-1];
            assign w_q_in   = r_q[g-1];
            assign w_den_in = r_den[g-1];
        end

        always_comb begin
            logic [SW:0] r1;
            n_x   = w_x_in;
            n_rem = w_rem_in;
            n_q   = w_q_in;
            r1    = '0;
            for (int j = 0; j < rmq_pkg::STEPS; j++) begin
                if (g * rmq_pkg::STEPS + j < NW) begin
                    r1  = {n_rem, n_x[NW-1]};
                    n_x = n_x << 1;
                    if (r1 >= {1'b0, w_den_in}) begin
                        n_rem = SW'(r1 - {1'b0, w_den_in});
                        n_q   = {n_q[NW-2:0], 1'b1};
                    end else begin
                        n_rem = SW'(r1);
                        n_q   = {n_q[NW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]   <= n_x;
                r_rem[g] <= n_rem;
                r_q[g]   <= n_q;
                r_den[g] <= w_den_in;
            end
        end
    end

    assign o_quo = r_q[rmq_pkg::DIV_LAT-1];

endmodule
